[rtl/core/ostt_pkg.sv]
// Package for the overlay slot translation table.
// Holds the item types, status and operation codes, and controller/datapath links.
// No dependencies.
package ostt_pkg;

  // Default sizing and reset value of the slot region base
  localparam int unsigned SLOT_COUNT_DEFAULT     = 32;
  localparam int unsigned SLOT_SIZE_LOG2_DEFAULT = 18;
  localparam logic [31:0] REGION_BASE_RESET      = 32'h8090_0000;

  // Operation codes
  typedef enum logic {
    OP_RESOLVE  = 1'b0,
    OP_ALLOCATE = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  // One input item
  typedef struct packed {
    op_t         operation;
    logic [31:0] virtual_address;
    logic [15:0] overlay_file_id;
  } in_t;

  // One result item
  typedef struct packed {
    logic [31:0] physical_address;
    status_t     status;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the item and restart the scan
    logic scan;    // issue one slot read, check the previous one
    logic commit;  // update the table and register the result
  } ostt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;   // slot under check matches
    logic last;  // slot under check is the final one
  } ostt_stat_t;

endpackage

[rtl/core/overlay_slot_translation_table.sv]
// Overlay slot translation table: top level.
// Joins ostt_ctrl and ostt_dp; depends on ostt_pkg.
//
// Usage:
//   Input channel: drive item and raise start; the item transfers at a rising
//   edge where start is high and busy is low. busy stays high until the
//   item's result has been registered.
//   Result channel: result_strobe is high for one cycle with result valid;
//   the receiver takes it in that cycle and cannot hold it off.
//   Configuration: cfg_we with cfg_wdata writes slot_region_base; write only
//   while busy is low.
//   Timing: slots are read one per cycle from the slot memory's single read
//   port, in index order, and the scan stops at the first matching slot.
//   The result is registered in the commit state that follows the scan; busy
//   falls in the cycle the result strobes, so a new item can transfer then.
//   Reset: all slots are invalid and slot_region_base returns to 0x80900000;
//   no clearing pass is needed.
module overlay_slot_translation_table
  import ostt_pkg::*;
#(
  parameter int unsigned SLOT_COUNT     = SLOT_COUNT_DEFAULT,
  parameter int unsigned SLOT_SIZE_LOG2 = SLOT_SIZE_LOG2_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_t         item,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        result_strobe,
  output out_t        result
);

  ostt_cmd_t  cmd;
  ostt_stat_t stat;

  // Sequencer
  ostt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Slot table and result path
  ostt_dp #(
    .SLOT_COUNT     (SLOT_COUNT),
    .SLOT_SIZE_LOG2 (SLOT_SIZE_LOG2)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .item          (item),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

[rtl/core/ostt_ctrl.sv]
// Controller for the overlay slot translation table.
// Sequences load, slot scan and commit; depends on ostt_pkg.
module ostt_ctrl
  import ostt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  ostt_stat_t stat,
  output ostt_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (stat.hit || stat.last) state <= ST_DONE;
        end
        ST_DONE: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Commands and handshake
  assign busy       = (state != ST_IDLE);
  assign cmd.load   = (state == ST_IDLE) && start;
  assign cmd.scan   = (state == ST_SCAN);
  assign cmd.commit = (state == ST_DONE);

`ifndef SYNTHESIS
  // The commit state is entered only straight from the scan state
  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> ($past(state) == ST_SCAN))
    else $error("commit without a preceding scan");
  // A new item is never taken while one is in flight
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd.scan && !cmd.commit)
    else $error("load while busy");
`endif

endmodule

[rtl/core/ostt_dp.sv]
// Datapath for the overlay slot translation table.
// Slot memories, valid bits, scan pipeline, result register; depends on ostt_pkg.
module ostt_dp
  import ostt_pkg::*;
#(
  parameter int unsigned SLOT_COUNT     = SLOT_COUNT_DEFAULT,
  parameter int unsigned SLOT_SIZE_LOG2 = SLOT_SIZE_LOG2_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  ostt_cmd_t   cmd,
  output ostt_stat_t  stat,
  input  in_t         item,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        result_strobe,
  output out_t        result
);

  localparam int unsigned IDX_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W    = $clog2(SLOT_COUNT + 1);
  localparam logic [31:0] WIN_SIZE = 32'(64'(1) << SLOT_SIZE_LOG2);

  // Slot storage
  logic [31:0] mem_vb [SLOT_COUNT];
  logic [31:0] mem_pb [SLOT_COUNT];
  logic [15:0] mem_fid [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid;

  logic [31:0] region_base;
  in_t         req;

  // Scan pipeline
  logic [CNT_W-1:0] addr_cnt;
  logic [IDX_W-1:0] rd_addr;
  logic             issue;
  logic             rd_ok;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      rd_vb;
  logic [31:0]      rd_pb;

  // Scan outcome
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [31:0]      hit_pb;
  logic [31:0]      hit_off;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // Commit controls
  logic             wr_new;
  logic             wr_fid;
  logic [IDX_W-1:0] wr_idx;
  logic [31:0]      new_pb;
  logic [31:0]      win_end;
  logic             match;
  out_t             res_next;

  assign rd_addr = addr_cnt[IDX_W-1:0];
  assign issue   = cmd.scan && (addr_cnt < CNT_W'(SLOT_COUNT));

  // Window and base compare on the slot just read
  always_comb begin
    win_end = rd_vb + WIN_SIZE;
    if (req.operation == OP_RESOLVE) begin
      match = (req.virtual_address >= rd_vb) && (req.virtual_address < win_end);
    end else begin
      match = (req.virtual_address == rd_vb);
    end
    match = match && rd_ok && rd_valid;
  end

  assign stat.hit  = match;
  assign stat.last = rd_ok && (rd_idx == IDX_W'(SLOT_COUNT - 1));

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= REGION_BASE_RESET;
    end else if (cfg_we) begin
      region_base <= cfg_wdata;
    end
  end

  // Scan control state
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_cnt   <= '0;
      rd_ok      <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      addr_cnt   <= '0;
      rd_ok      <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan) begin
      rd_ok <= issue;
      if (issue) addr_cnt <= addr_cnt + CNT_W'(1);
      if (match) hit <= 1'b1;
      if (rd_ok && !rd_valid && !free_found) free_found <= 1'b1;
    end
  end

  // Scan payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) req <= item;
    if (issue) begin
      rd_idx   <= rd_addr;
      rd_valid <= valid[rd_addr];
    end
    if (cmd.scan && match) begin
      hit_idx <= rd_idx;
      hit_pb  <= rd_pb;
      hit_off <= req.virtual_address - rd_vb;
    end
    if (cmd.scan && rd_ok && !rd_valid && !free_found) free_idx <= rd_idx;
  end

  // Commit decisions
  always_comb begin
    new_pb   = region_base + (32'(free_idx) << SLOT_SIZE_LOG2);
    wr_new   = 1'b0;
    wr_fid   = 1'b0;
    wr_idx   = hit ? hit_idx : free_idx;
    res_next = '{physical_address: 32'd0, status: STATUS_OK};
    if (req.operation == OP_RESOLVE) begin
      if (hit) res_next.physical_address = hit_pb + hit_off;
      else     res_next.status = STATUS_MISS;
    end else if (hit) begin
      wr_fid = cmd.commit;
      res_next.physical_address = hit_pb;
    end else if (free_found) begin
      wr_new = cmd.commit;
      wr_fid = cmd.commit;
      res_next.physical_address = new_pb;
    end else begin
      res_next.status = STATUS_FULL;
    end
  end

  // Slot memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_new) begin
      mem_vb[wr_idx] <= req.virtual_address;
      mem_pb[wr_idx] <= new_pb;
    end
    if (wr_fid) mem_fid[wr_idx] <= req.overlay_file_id;
    if (issue) begin
      rd_vb <= mem_vb[rd_addr];
      rd_pb <= mem_pb[rd_addr];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_new) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.commit;
    end
    if (cmd.commit) result <= res_next;
  end

`ifndef SYNTHESIS
  // Slots are never released, so the count of valid slots never drops
  a_valid_monotonic: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) >= $countones($past(valid)))
    else $error("valid slot lost");
  // A full status means every slot really is valid
  a_full_true: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && res_next.status == STATUS_FULL) |-> (&valid))
    else $error("full reported with a free slot");
  // Each result follows exactly one commit
  a_strobe_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result_strobe)
    else $error("commit without result");
  // A new slot is claimed only where that slot is not yet valid
  a_claim_free: assert property (@(posedge clk) disable iff (rst)
    wr_new |-> !valid[wr_idx])
    else $error("claim of a valid slot");
`endif

endmodule

[bench/tb_overlay_slot_translation_table.sv]
// Self-checking bench for the overlay slot translation table: resolve and
// allocate transfers with region base writes, checked against a slot predictor.
// Depends on ostt_pkg and overlay_slot_translation_table.
module tb_overlay_slot_translation_table;
  import ostt_pkg::*;

  localparam int unsigned SLOT_COUNT     = SLOT_COUNT_DEFAULT;
  localparam int unsigned SLOT_SIZE_LOG2 = SLOT_SIZE_LOG2_DEFAULT;
  localparam logic [31:0] WINDOW         = 32'd1 << SLOT_SIZE_LOG2;

  // Stimulus steps handed to the driver
  typedef enum {
    STEP_ITEM,   // offer one input item
    STEP_CFG,    // write slot_region_base once idle
    STEP_DRAIN,  // hold off until every expected result has come
    STEP_PACE    // change the sender idle rate
  } step_kind_t;

  typedef struct {
    step_kind_t  kind;
    in_t         req;
    logic [31:0] value;
    int unsigned pct;
  } step_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  in_t         item = '0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        result_strobe;
  out_t        result;

  overlay_slot_translation_table #(
    .SLOT_COUNT    (SLOT_COUNT),
    .SLOT_SIZE_LOG2(SLOT_SIZE_LOG2)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_strobe(result_strobe),
    .result       (result)
  );

  // Predicted table state and region base
  logic        slot_valid [SLOT_COUNT];
  logic [31:0] slot_vbase [SLOT_COUNT];
  logic [31:0] slot_pbase [SLOT_COUNT];
  logic [15:0] slot_fid   [SLOT_COUNT];
  logic [31:0] model_region_base = REGION_BASE_RESET;

  step_t       stim_queue[$];
  out_t        expected_translations[$];
  logic [31:0] gen_bases[$];   // virtual bases the generator has tried to allocate
  int unsigned items_sent = 0;
  int unsigned results_taken = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) slot_valid[i] = 1'b0;
  end

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Works out one result and updates the predicted table
  function automatic out_t predict_translation(input in_t req);
    out_t        res;
    int          open_slot;
    logic [31:0] win_end;
    logic [31:0] idx_off;
    bit          done;
    res.physical_address = '0;
    res.status = STATUS_MISS;
    open_slot = -1;
    done = 1'b0;
    if (req.operation == OP_RESOLVE) begin
      // first valid slot whose window holds the address; end wraps mod 2^32
      for (int i = 0; i < SLOT_COUNT; i++) begin
        win_end = slot_vbase[i] + WINDOW;
        if (!done && slot_valid[i] && req.virtual_address >= slot_vbase[i] &&
            req.virtual_address < win_end) begin
          res.physical_address = slot_pbase[i] + (req.virtual_address - slot_vbase[i]);
          res.status = STATUS_OK;
          done = 1'b1;
        end
      end
    end else begin
      // reuse an equal base, else note the lowest free slot
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (!done && slot_valid[i] && slot_vbase[i] == req.virtual_address) begin
          slot_fid[i] = req.overlay_file_id;
          res.physical_address = slot_pbase[i];
          res.status = STATUS_OK;
          done = 1'b1;
        end
        if (open_slot < 0 && !slot_valid[i]) open_slot = i;
      end
      if (!done) begin
        if (open_slot < 0) begin
          res.physical_address = '0;
          res.status = STATUS_FULL;
        end else begin
          idx_off = 32'(open_slot);
          idx_off = idx_off << SLOT_SIZE_LOG2;
          slot_valid[open_slot] = 1'b1;
          slot_vbase[open_slot] = req.virtual_address;
          slot_pbase[open_slot] = model_region_base + idx_off;
          slot_fid[open_slot] = req.overlay_file_id;
          res.physical_address = slot_pbase[open_slot];
          res.status = STATUS_OK;
        end
      end
    end
    return res;
  endfunction

  // Stimulus queue helpers
  task automatic add_item(input op_t op, input logic [31:0] va, input logic [15:0] fid);
    step_t s;
    s.kind = STEP_ITEM;
    s.req.operation = op;
    s.req.virtual_address = va;
    s.req.overlay_file_id = fid;
    s.value = '0;
    s.pct = 0;
    stim_queue.push_back(s);
  endtask

  task automatic add_ctrl(input step_kind_t kind, input logic [31:0] value,
                          input int unsigned pct);
    step_t s;
    s.kind = kind;
    s.req = '0;
    s.value = value;
    s.pct = pct;
    stim_queue.push_back(s);
  endtask

  // Random items: mostly resolves aimed at known windows and reuses, some new
  // bases so the table fills up, and a little noise
  task automatic gen_random(input int unsigned count);
    int unsigned r;
    logic [31:0] va;
    logic [31:0] base;
    logic [15:0] fid;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(99);
      fid = 16'($urandom_range(16'hFFFF));
      if (gen_bases.size() == 0 || r < 3) begin
        case ($urandom_range(3))
          0: va = $urandom;
          1: va = $urandom & 32'hFFFC_0000;
          2: va = 32'hFFFF_FFFF - $urandom_range(WINDOW);
          default: va = $urandom_range(WINDOW);
        endcase
        gen_bases.push_back(va);
        add_item(OP_ALLOCATE, va, fid);
      end else if (r < 25) begin
        add_item(OP_ALLOCATE, gen_bases[$urandom_range(gen_bases.size() - 1)], fid);
      end else if (r < 94) begin
        base = gen_bases[$urandom_range(gen_bases.size() - 1)];
        case ($urandom_range(5))
          0: va = base;
          1: va = base + WINDOW - 1;
          2: va = base + WINDOW;
          3: va = base - 1;
          4: va = base + $urandom_range(2 * WINDOW);
          default: va = base + $urandom_range(WINDOW - 1);
        endcase
        add_item(OP_RESOLVE, va, fid);
      end else begin
        add_item(op_t'($urandom_range(1)), $urandom, fid);
      end
    end
  endtask

  // Driver: offers queued steps; one nonblocking write per signal per edge
  always @(posedge clk) begin : drive_proc
    logic nxt_start;
    logic nxt_we;
    logic quiet;
    if (rst) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      nxt_start = start;
      nxt_we = 1'b0;
      if (start && !busy) begin
        expected_translations.push_back(predict_translation(item));
        items_sent++;
        nxt_start = 1'b0;
      end
      if (cfg_we) model_region_base = cfg_wdata;
      quiet = (items_sent == results_taken) && !busy && !nxt_start;
      if (!nxt_start && stim_queue.size() > 0) begin
        case (stim_queue[0].kind)
          STEP_ITEM: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              nxt_start = 1'b1;
              item <= stim_queue[0].req;
              void'(stim_queue.pop_front());
            end
          end
          STEP_CFG: begin
            if (quiet) begin
              nxt_we = 1'b1;
              cfg_wdata <= stim_queue[0].value;
              void'(stim_queue.pop_front());
            end
          end
          STEP_DRAIN: begin
            if (quiet) void'(stim_queue.pop_front());
          end
          default: begin
            send_idle_pct = stim_queue[0].pct;
            void'(stim_queue.pop_front());
          end
        endcase
      end
      start <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  // Monitor: each strobed result against the oldest expectation
  always @(posedge clk) begin : monitor_proc
    out_t want;
    if (!rst && result_strobe) begin
      if (expected_translations.size() == 0) begin
        report_mismatch($sformatf("result %h/%0d with nothing expected",
                                  result.physical_address, result.status));
      end else begin
        want = expected_translations.pop_front();
        if (result.physical_address !== want.physical_address)
          report_mismatch($sformatf("physical_address got %h want %h",
                                    result.physical_address, want.physical_address));
        if (result.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    result.status, want.status));
      end
      results_taken <= results_taken + 1;
    end
  end

  // Stimulus plan, then wait for the drain and report
  initial begin
    add_ctrl(STEP_PACE, '0, 27);

    // Directed part under the reset region base
    add_item(OP_RESOLVE,  32'h0000_0000, 16'h0000);   // empty table miss
    add_item(OP_RESOLVE,  32'hFFFF_FFFF, 16'hFFFF);
    add_item(OP_ALLOCATE, 32'h0000_0000, 16'h0000);   // slot 0
    add_item(OP_ALLOCATE, 32'h1000_0000, 16'hFFFF);   // slot 1
    add_item(OP_RESOLVE,  32'h0000_0000, 16'h0000);
    add_item(OP_RESOLVE,  32'h0003_FFFF, 16'h0000);   // last byte of window
    add_item(OP_RESOLVE,  32'h0004_0000, 16'h0000);   // just past window
    add_item(OP_ALLOCATE, 32'h0000_0000, 16'h1234);   // reuse
    add_item(OP_ALLOCATE, 32'hFFFF_FFFF, 16'hA5A5);   // window end wraps
    add_item(OP_RESOLVE,  32'hFFFF_FFFF, 16'h0000);
    add_item(OP_ALLOCATE, 32'hFFFC_0000, 16'h5A5A);   // window end wraps to zero
    add_item(OP_RESOLVE,  32'hFFFC_0000, 16'h0000);
    add_item(OP_RESOLVE,  32'h1003_FFFF, 16'h0000);

    // All-ones base: physical bases of later slots wrap
    add_ctrl(STEP_CFG, 32'hFFFF_FFFF, 0);
    add_item(OP_ALLOCATE, 32'h2000_0000, 16'h0001);
    add_item(OP_RESOLVE,  32'h2000_0001, 16'h0000);
    add_item(OP_ALLOCATE, 32'h0000_0000, 16'h0002);   // reuse keeps old physical base
    add_item(OP_ALLOCATE, 32'h0002_0000, 16'h0003);   // overlaps slot 0
    add_item(OP_RESOLVE,  32'h0003_0000, 16'h0000);   // first slot wins
    add_item(OP_RESOLVE,  32'h0005_0000, 16'h0000);

    add_ctrl(STEP_CFG, 32'h0000_0000, 0);
    add_item(OP_ALLOCATE, 32'h3000_0000, 16'h8000);
    add_item(OP_RESOLVE,  32'h3001_2345, 16'h0000);
    gen_bases.push_back(32'h0000_0000);
    gen_bases.push_back(32'h1000_0000);
    gen_bases.push_back(32'h2000_0000);
    gen_bases.push_back(32'h3000_0000);

    // Random part across idle settings and base values
    gen_random(250);
    add_ctrl(STEP_CFG, $urandom, 0);
    gen_random(150);
    add_ctrl(STEP_PACE, '0, 79);
    add_ctrl(STEP_CFG, $urandom, 0);
    gen_random(150);
    add_ctrl(STEP_DRAIN, '0, 0);
    gen_random(50);
    add_ctrl(STEP_PACE, '0, 0);
    add_ctrl(STEP_CFG, REGION_BASE_RESET, 0);
    gen_random(200);

    @(negedge rst);
    do @(posedge clk);
    while (stim_queue.size() != 0 || start || items_sent != results_taken);
    repeat (SLOT_COUNT + 8) @(posedge clk);
    if (expected_translations.size() != 0)
      report_mismatch($sformatf("%0d expected results never came",
                                expected_translations.size()));
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sim.f]
rtl/core/ostt_pkg.sv
rtl/core/ostt_ctrl.sv
rtl/core/ostt_dp.sv
rtl/core/overlay_slot_translation_table.sv
bench/tb_overlay_slot_translation_table.sv
